// ===== rtl/vsa_pkg.sv =====
// Shared types and constants for the ascending vector sorter.
// No dependencies; every other file of the block imports this package.
package vsa_pkg;

    localparam int DATA_W = 32;

    // One element of the vector as it arrives.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_item;

    // One sorted element as it leaves.
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_run;
        logic                     overflowed;
    } t_out_item;

    // Port controls from the sequencer to the element store.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

// ===== rtl/vsa_store.sv =====
// Element store: one write port and one read port with registered read data.
// Depends on vsa_pkg for the data width and the port control struct.
module vsa_store
    import vsa_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                     i_clk,
    input  t_mem_ctl                 i_ctl,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read enable.
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vsa_seq.sv =====
// Sequencer: loads elements by insertion into the store with one shared
// signed comparator, then reads the store out in order.
// Depends on vsa_pkg and drives vsa_store through its port controls.
module vsa_seq
    import vsa_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input channel.
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_item,
    // Result hand-off to the output register.
    input  logic                     i_out_free,
    output logic                     o_emit,
    output t_out_item                o_emit_item,
    // Store ports.
    output t_mem_ctl                 o_mem_ctl,
    output logic [AW-1:0]            o_waddr,
    output logic signed [DATA_W-1:0] o_wdata,
    output logic [AW-1:0]            o_raddr,
    input  logic signed [DATA_W-1:0] i_rdata
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_ERD   = 3'd4;
    localparam logic [2:0] S_EWAIT = 3'd5;

    localparam logic [CW-1:0] FULL = CW'(CAPACITY);

    logic [2:0]               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_ovf,   n_ovf;
    logic                     r_last,  n_last;
    logic [AW-1:0]            r_j,     n_j;
    logic [AW-1:0]            r_k,     n_k;
    logic signed [DATA_W-1:0] r_key,   n_key;

    logic accept;
    logic key_less;
    logic at_end;

    assign accept   = i_in_valid && (r_state == S_LOAD);
    assign key_less = r_key < i_rdata;
    assign at_end   = (CW'(r_k) + CW'(1)) == r_count;

    // Next-state logic and store port control.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_j         = r_j;
        n_k         = r_k;
        n_key       = r_key;
        o_mem_ctl   = '0;
        o_waddr     = r_j;
        o_wdata     = r_key;
        o_raddr     = r_j - AW'(1);
        o_emit      = 1'b0;
        o_emit_item = '0;
        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    n_last = i_in_item.last;
                    n_k    = '0;
                    if (r_count == FULL) begin
                        // Store full: drop the element, still honor the last mark.
                        n_ovf = 1'b1;
                        if (i_in_item.last) begin
                            n_state = S_ERD;
                        end
                    end else if (r_count == '0) begin
                        // First element goes straight to the bottom entry.
                        o_mem_ctl.we = 1'b1;
                        o_waddr      = '0;
                        o_wdata      = i_in_item.value;
                        n_count      = CW'(1);
                        if (i_in_item.last) begin
                            n_state = S_ERD;
                        end
                    end else begin
                        n_key   = i_in_item.value;
                        n_j     = r_count[AW-1:0];
                        n_count = r_count + CW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                // Fetch the neighbor below the hole.
                o_mem_ctl.re = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                if (key_less) begin
                    // Neighbor moves up into the hole.
                    o_mem_ctl.we = 1'b1;
                    o_wdata      = i_rdata;
                    n_j          = r_j - AW'(1);
                    n_state      = (r_j == AW'(1)) ? S_PLACE : S_RD;
                end else begin
                    o_mem_ctl.we = 1'b1;
                    n_state      = r_last ? S_ERD : S_LOAD;
                end
            end
            S_PLACE: begin
                o_mem_ctl.we = 1'b1;
                n_state      = r_last ? S_ERD : S_LOAD;
            end
            S_ERD: begin
                o_raddr      = r_k;
                o_mem_ctl.re = 1'b1;
                n_state      = S_EWAIT;
            end
            S_EWAIT: begin
                o_raddr = r_k;
                if (i_out_free) begin
                    o_emit                   = 1'b1;
                    o_emit_item.sorted_value = i_rdata;
                    o_emit_item.end_of_run   = at_end;
                    o_emit_item.overflowed   = r_ovf;
                    if (at_end) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_j    <= n_j;
        r_k    <= n_k;
        r_key  <= n_key;
    end

    assign o_in_stall = (r_state != S_LOAD);

endmodule

// ===== rtl/vector_sort_ascending_top.sv =====
// Ascending sorter for vectors of signed 32-bit elements. Elements enter one
// per item; each is placed by insertion into a CAPACITY-entry store with a
// single shared signed comparator. The first element of a vector and a dropped
// element are taken in S_LOAD alone. Any other element reads the neighbor below
// its slot in S_RD through the store's registered read port and compares it in
// S_CMP; while the neighbor is larger it moves up and the next one is read, and
// the new element is written in S_CMP or, at the bottom entry, in S_PLACE.
// Input stall is high while an element is being placed and while a vector's
// results are read out. After the element marked last, the held elements leave
// in ascending order, each read in S_ERD and handed on in S_EWAIT once the
// output register is free; the last result carries end_of_run, and every
// result carries overflowed when elements beyond CAPACITY were dropped.
// Results sit in an output register, so the next vector may start loading while the final result waits.
// Depends on vsa_pkg, vsa_store and vsa_seq.
module vector_sort_ascending_top
    import vsa_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    t_mem_ctl                 mem_ctl;
    logic [AW-1:0]            waddr;
    logic [AW-1:0]            raddr;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] rdata;
    logic                     emit;
    t_out_item                emit_item;
    logic                     out_free;

    logic                     r_out_valid;
    t_out_item                r_out_item;

    vsa_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    vsa_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_free  (out_free),
        .o_emit      (emit),
        .o_emit_item (emit_item),
        .o_mem_ctl   (mem_ctl),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    // The output register can take a new item when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/vsa_check.sv =====
// Port-level checker for the ascending vector sorter, bound to the top level.
// Depends on vsa_pkg for the item types.
module vsa_check
    import vsa_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                     out_acc;
    logic                     r_open;
    logic                     r_prev_ovf;
    logic signed [DATA_W-1:0] r_prev;
    logic [CW-1:0]            r_cnt;

    assign out_acc = o_out_valid && !i_out_stall;

    // Track the previous result of the run in progress.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_cnt  <= '0;
        end else if (out_acc) begin
            r_open <= !o_out_item.end_of_run;
            r_cnt  <= o_out_item.end_of_run ? '0 : r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev     <= o_out_item.sorted_value;
            r_prev_ovf <= o_out_item.overflowed;
        end
    end

    // A stalled input item stays offered and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("stalled input item changed");

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Results of one run come out in ascending order.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_open |-> o_out_item.sorted_value >= r_prev)
        else $error("results out of ascending order");

    // The overflow flag is the same on every result of a run.
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_open |-> o_out_item.overflowed == r_prev_ovf)
        else $error("overflow flag changed within a run");

    // No run has more results than the store holds.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_cnt < CW'(CAPACITY))
        else $error("run longer than capacity");

endmodule

bind vector_sort_ascending_top vsa_check #(
    .CAPACITY (CAPACITY)
) u_vsa_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
